// ----- rtl/hgm_pkg.sv -----
package hgm_pkg;

  localparam int HEIGHT_W = 32;
  localparam int GRAY_W   = 8;
  localparam int CMD_W    = 2;

  // starting values of a scan
  localparam logic signed [HEIGHT_W-1:0] LOW_START  = 32'sd100000000;
  localparam logic signed [HEIGHT_W-1:0] HIGH_START = -32'sd100000000;

  localparam logic [GRAY_W-1:0] GRAY_MAX = 8'hff;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_SCAN  = 2'd1,
    CMD_MAP   = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_NUM,
    S_DIV,
    S_OUT
  } state_t;

endpackage

// ----- rtl/height_to_gray_level_mapper_core.sv -----
// Inverted 8-bit min-max normalisation of grid heights. Each word carries a
// command: clear resets the tracked minimum and maximum, scan folds a height into
// them, and map returns gray_level = 255 - ceil(255*(height-min)/(top-min)), where
// top is the maximum or 1 when the maximum is zero. A zero or negative span and a
// height below the minimum give 255, a height above top gives 0. Clear, scan and
// the unused command give no result. A map word in range passes through one range
// check, one numerator build, eight steps of a shared restoring subtract-and-compare
// stage, one per quotient bit, and one output load before its result is offered.
// A bad span or a height out of range goes straight from the range check to the
// output load, which waits while an earlier result still waits for out_ready.
// in_ready is low from the accepted map word until its result is loaded. Grid
// walking is up to the host.
module height_to_gray_level_mapper_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic signed [31:0] height,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  gray_level
);

  hgm_pkg::state_t state, state_next;

  logic signed [31:0] lowest_height;
  logic signed [31:0] highest_height;
  logic signed [31:0] sample;
  logic [31:0]        span;
  logic [31:0]        delta;
  logic [31:0]        rem;
  logic [7:0]         numer;
  logic [6:0]         quot;
  logic [7:0]         result;
  logic [2:0]         cnt;

  logic               in_fire;
  logic               out_free;

  // range check terms
  logic signed [31:0] top;
  logic signed [32:0] span_wide;
  logic signed [32:0] delta_wide;
  logic               span_bad;
  logic               below;
  logic               above;

  // numerator 255*delta + span - 1, below 256*span
  logic [39:0]        num_wide;

  // shared divider step
  logic [32:0]        cand;
  logic               ge;
  logic [32:0]        cand_diff;

  assign in_ready = (state == hgm_pkg::S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign top        = (highest_height == '0) ? 32'sd1 : highest_height;
  assign span_wide  = {top[31], top} - {lowest_height[31], lowest_height};
  assign delta_wide = {sample[31], sample} - {lowest_height[31], lowest_height};
  assign span_bad   = (span_wide <= 33'sd0);
  assign below      = (sample < lowest_height);
  assign above      = (sample > top);

  assign num_wide = {delta, 8'h00} - {8'h00, delta} + {8'h00, span} - 40'd1;

  assign cand      = {rem, numer[7]};
  assign ge        = (cand >= {1'b0, span});
  assign cand_diff = cand - {1'b0, span};

  always_comb begin
    state_next = state;
    case (state)
      hgm_pkg::S_IDLE: begin
        if (in_fire && (cmd == hgm_pkg::CMD_MAP)) state_next = hgm_pkg::S_PREP;
      end
      hgm_pkg::S_PREP: begin
        if (span_bad || below || above) state_next = hgm_pkg::S_OUT;
        else state_next = hgm_pkg::S_NUM;
      end
      hgm_pkg::S_NUM: state_next = hgm_pkg::S_DIV;
      hgm_pkg::S_DIV: begin
        if (cnt == '0) state_next = hgm_pkg::S_OUT;
      end
      hgm_pkg::S_OUT: begin
        if (out_free) state_next = hgm_pkg::S_IDLE;
      end
      default: state_next = hgm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hgm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lowest_height  <= hgm_pkg::LOW_START;
      highest_height <= hgm_pkg::HIGH_START;
      out_valid      <= 1'b0;
      cnt            <= '0;
    end else begin
      if (in_fire) begin
        case (cmd)
          hgm_pkg::CMD_CLEAR: begin
            lowest_height  <= hgm_pkg::LOW_START;
            highest_height <= hgm_pkg::HIGH_START;
          end
          hgm_pkg::CMD_SCAN: begin
            if (height > highest_height) highest_height <= height;
            if (height < lowest_height) lowest_height <= height;
          end
          default: ;
        endcase
      end
      if (state == hgm_pkg::S_NUM) cnt <= 3'd7;
      else if (state == hgm_pkg::S_DIV) cnt <= cnt - 3'd1;
      if ((state == hgm_pkg::S_OUT) && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) sample <= height;
    case (state)
      hgm_pkg::S_PREP: begin
        span  <= span_wide[31:0];
        delta <= delta_wide[31:0];
        if (span_bad || below) result <= hgm_pkg::GRAY_MAX;
        else result <= '0;
      end
      hgm_pkg::S_NUM: begin
        rem   <= num_wide[39:8];
        numer <= num_wide[7:0];
      end
      hgm_pkg::S_DIV: begin
        rem   <= ge ? cand_diff[31:0] : cand[31:0];
        numer <= {numer[6:0], 1'b0};
        quot  <= {quot[5:0], ge};
        if (cnt == '0) result <= ~{quot, ge};
      end
      default: ;
    endcase
    if ((state == hgm_pkg::S_OUT) && out_free) gray_level <= result;
  end

  a_scan_order: assert property (@(posedge clk) disable iff (rst)
    (in_fire && (cmd == hgm_pkg::CMD_SCAN)) |=> (lowest_height <= highest_height))
    else $error("min above max after a scan");

  a_rem_below_span: assert property (@(posedge clk) disable iff (rst)
    (state == hgm_pkg::S_DIV) |-> (rem < span))
    else $error("divider remainder not below span");

  a_map_busy: assert property (@(posedge clk) disable iff (rst)
    (in_fire && (cmd == hgm_pkg::CMD_MAP)) |=> !in_ready)
    else $error("ready during a map word");

endmodule
